FILE: rtl/crc32cmb_pkg.sv
// Package for the CRC-32 combine block: operator types, constants and the zero-byte operator table.
`default_nettype none
package crc32cmb_pkg;

    localparam int CRC_W = 32;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    // The table holds one operator per length bit, for up to 64 length bits.
    localparam int OP_DEPTH = 64;
    localparam int OP_IDX_W = 6;

    // A 32x32 GF(2) operator, stored as 32 columns of 32 bits.
    typedef logic [CRC_W-1:0][CRC_W-1:0] t_op;
    typedef t_op [OP_DEPTH-1:0] t_op_tbl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // Multiplies operator m by vector v: XOR of the columns selected by v.
    function automatic logic [CRC_W-1:0] op_apply(input t_op m, input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < CRC_W; i++) begin
            if (v[i]) begin
                acc = acc ^ m[i];
            end
        end
        return acc;
    endfunction

    function automatic t_op op_square(input t_op m);
        t_op r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = op_apply(m, m[i]);
        end
        return r;
    endfunction

    // Entry k feeds 2^k zero bytes through the CRC register.
    function automatic t_op_tbl build_op_table();
        t_op op;
        t_op_tbl tbl;
        op[0] = CRC_POLY;
        for (int i = 1; i < CRC_W; i++) begin
            op[i] = CRC_W'(1) << (i - 1);
        end
        // One zero bit, squared three times, gives one zero byte.
        op = op_square(op);
        op = op_square(op);
        op = op_square(op);
        tbl[0] = op;
        for (int k = 1; k < OP_DEPTH; k++) begin
            tbl[k] = op_square(tbl[k-1]);
        end
        return tbl;
    endfunction

    localparam t_op_tbl OP_TABLE = build_op_table();

endpackage
`default_nettype wire

FILE: rtl/crc32_combine_by_length.sv
// Top level of the CRC-32 combine block: length-bit sequencer around one shared operator apply unit.
//
// Usage: an input beat on the s_axis channel carries the CRC-32 of a leading segment,
// the CRC-32 of a trailing segment and the trailing segment's byte length. One output
// beat on the m_axis channel returns the CRC-32 of the two segments joined.
// The block walks the length one bit per cycle, lowest bit first. In each cycle the
// single 32x32 GF(2) apply unit multiplies the running CRC by the zero-byte operator
// for that bit position, taken from a constant table, where the bit is set.
// Output valid rises once the walk has passed h, the position of the highest set
// length bit (h + 1 <= LENGTH_BITS); a zero length skips the walk. One item is in
// work at a time and s_axis tready is low meanwhile, so a new item is not taken
// before the last one has left the sequencer.
// The result sits in an output register; while the receiver stalls, a finished item
// waits in the sequencer and the next input beat is not taken until the output
// register frees. Reset (synchronous, active low) empties the output register and
// returns the sequencer to idle.
`default_nettype none
module crc32_combine_by_length #(
    parameter int LENGTH_BITS = 63
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // Fields from bit 0: first_crc[31:0], second_crc[31:0], second_length[LENGTH_BITS-1:0].
    input  wire  [((2 * crc32cmb_pkg::CRC_W + LENGTH_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    // Fields from bit 0: combined_crc[31:0].
    output logic [crc32cmb_pkg::CRC_W-1:0] o_m_axis_tdata
);

    localparam int CW = crc32cmb_pkg::CRC_W;

    crc32cmb_pkg::t_state r_state, n_state;
    logic [CW-1:0]                      r_a, n_a;
    logic [CW-1:0]                      r_b, n_b;
    logic [LENGTH_BITS-1:0]             r_len, n_len;
    logic [crc32cmb_pkg::OP_IDX_W-1:0]  r_k, n_k;
    logic                               r_ov, n_ov;
    logic [CW-1:0]                      r_out, n_out;

    logic [CW-1:0]          apply_res;
    logic [LENGTH_BITS-1:0] in_len;
    logic                   in_fire;
    logic                   out_free;

    assign in_len   = i_s_axis_tdata[2*CW +: LENGTH_BITS];
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ov || i_m_axis_tready;

    // The shared unit: operator for 2^k zero bytes times the running CRC.
    assign apply_res = crc32cmb_pkg::op_apply(crc32cmb_pkg::OP_TABLE[r_k], r_a);

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_len   = r_len;
        n_k     = r_k;
        n_ov    = r_ov;
        n_out   = r_out;
        o_s_axis_tready = (r_state == crc32cmb_pkg::S_IDLE);

        if (r_ov && i_m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            crc32cmb_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_a   = i_s_axis_tdata[0 +: CW];
                    n_len = in_len;
                    n_k   = '0;
                    // A zero length returns the leading CRC untouched.
                    if (in_len == '0) begin
                        n_b     = '0;
                        n_state = crc32cmb_pkg::S_DONE;
                    end else begin
                        n_b     = i_s_axis_tdata[CW +: CW];
                        n_state = crc32cmb_pkg::S_RUN;
                    end
                end
            end
            crc32cmb_pkg::S_RUN: begin
                if (r_len[0]) begin
                    n_a = apply_res;
                end
                n_len = r_len >> 1;
                n_k   = r_k + crc32cmb_pkg::OP_IDX_W'(1);
                if ((r_len >> 1) == '0) begin
                    n_state = crc32cmb_pkg::S_DONE;
                end
            end
            crc32cmb_pkg::S_DONE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_out   = r_a ^ r_b;
                    n_state = crc32cmb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = crc32cmb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crc32cmb_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_len <= n_len;
        r_k   <= n_k;
        r_out <= n_out;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_out;

`ifndef SYNTH
    a_run_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == crc32cmb_pkg::S_RUN) |-> (r_len != '0))
        else $error("sequencer running with no length bits left");

    a_k_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == crc32cmb_pkg::S_RUN && n_state == crc32cmb_pkg::S_RUN)
        |=> (r_k == $past(r_k) + crc32cmb_pkg::OP_IDX_W'(1)))
        else $error("table index did not advance during the walk");

    a_zero_len_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && in_len == '0) |=> (r_state == crc32cmb_pkg::S_DONE && r_b == '0))
        else $error("zero length item did not go straight to done");

    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == crc32cmb_pkg::S_DONE && out_free) |=> (r_ov && r_out == $past(r_a ^ r_b)))
        else $error("finished item not moved to the output register");
`endif

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for the CRC-32 combine block: a directed table, then random beats checked by a predictor.
`timescale 1ns / 100ps

module tb;

    localparam int LEN_BITS = 63;
    localparam int CRC_BITS = crc32cmb_pkg::CRC_W;
    localparam int TDATA_W = ((2 * CRC_BITS + LEN_BITS + 7) / 8) * 8;
    localparam logic [CRC_BITS-1:0] POLY_REFLECTED = crc32cmb_pkg::CRC_POLY;
    localparam int NUM_ROWS = 16;
    localparam int RANDOM_PER_PHASE = 462;
    localparam int DRAIN_CYCLES = LEN_BITS + 8;

    // Operator columns: column i is the image of the unit vector with bit i set.
    typedef logic [CRC_BITS-1:0][CRC_BITS-1:0] t_gf2_mat;

    typedef struct {
        logic [CRC_BITS-1:0] first_crc;
        logic [CRC_BITS-1:0] second_crc;
        logic [LEN_BITS-1:0] second_len;
        bit                  known;
        logic [CRC_BITS-1:0] joined_crc;
    } t_crc_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // Fields from bit 0: first_crc[31:0], second_crc[31:0], second_length[62:0], zero pad.
    logic [TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // Fields from bit 0: combined_crc[31:0].
    logic [CRC_BITS-1:0]  o_m_axis_tdata;

    t_gf2_mat            byte_shift_ops [LEN_BITS];
    logic [CRC_BITS-1:0] joined_crc_q [$];
    t_crc_row            dir_rows [NUM_ROWS];
    int                  error_count = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;

    crc32_combine_by_length #(
        .LENGTH_BITS(LEN_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        $display("tb: error at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Runs the CRC register over eight zero bits, one shift per bit.
    function automatic logic [CRC_BITS-1:0] shift_zero_byte(input logic [CRC_BITS-1:0] crc);
        logic [CRC_BITS-1:0] r;
        r = crc;
        for (int n = 0; n < 8; n++) begin
            r = r[0] ? ((r >> 1) ^ POLY_REFLECTED) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [CRC_BITS-1:0] mat_times_vec(input t_gf2_mat m,
                                                          input logic [CRC_BITS-1:0] v);
        logic [CRC_BITS-1:0] acc;
        acc = '0;
        for (int i = 0; i < CRC_BITS; i++) begin
            if (v[i]) begin
                acc ^= m[i];
            end
        end
        return acc;
    endfunction

    // Entry k shifts 2^k zero bytes; each entry is the previous one composed with itself.
    task automatic build_shift_ops();
        for (int i = 0; i < CRC_BITS; i++) begin
            byte_shift_ops[0][i] = shift_zero_byte(CRC_BITS'(1) << i);
        end
        for (int k = 1; k < LEN_BITS; k++) begin
            for (int i = 0; i < CRC_BITS; i++) begin
                byte_shift_ops[k][i] = mat_times_vec(byte_shift_ops[k-1], byte_shift_ops[k-1][i]);
            end
        end
    endtask

    function automatic logic [CRC_BITS-1:0] predict_joined_crc(input logic [CRC_BITS-1:0] a,
                                                               input logic [CRC_BITS-1:0] b,
                                                               input logic [LEN_BITS-1:0] len);
        logic [CRC_BITS-1:0] acc;
        acc = a;
        if (len == '0) begin
            return a;
        end
        for (int k = 0; k < LEN_BITS; k++) begin
            if (len[k]) begin
                acc = mat_times_vec(byte_shift_ops[k], acc);
            end
        end
        return acc ^ b;
    endfunction

    function automatic logic [CRC_BITS-1:0] rand_crc();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mixes zero, short, single-bit, all-ones and random-width lengths.
    function automatic logic [LEN_BITS-1:0] rand_length();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return '0;
            1: return LEN_BITS'($urandom_range(255, 1));
            2: return LEN_BITS'(1) << $urandom_range(LEN_BITS - 1);
            3: return '1;
            4, 5: return LEN_BITS'(raw) >> $urandom_range(LEN_BITS - 1);
            default: return LEN_BITS'(raw);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic [CRC_BITS-1:0] a, input logic [CRC_BITS-1:0] b,
                             input logic [LEN_BITS-1:0] len, input bit known,
                             input logic [CRC_BITS-1:0] typed_crc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= TDATA_W'({len, b, a});
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) begin
                break;
            end
        end
        joined_crc_q.push_back(known ? typed_crc : predict_joined_crc(a, b, len));
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        while (joined_crc_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (joined_crc_q.size() == 0) begin
                report_error($sformatf("result beat %08h with nothing expected", o_m_axis_tdata));
            end else if (o_m_axis_tdata !== joined_crc_q[0]) begin
                report_error($sformatf("combined_crc got %08h expected %08h",
                                       o_m_axis_tdata, joined_crc_q.pop_front()));
            end else begin
                void'(joined_crc_q.pop_front());
            end
        end
    end

    initial begin
        dir_rows[0]  = '{32'h0000_0000, 32'h0000_0000, 63'h0, 1'b1, 32'h0000_0000};
        dir_rows[1]  = '{32'hFFFF_FFFF, 32'h1234_5678, 63'h0, 1'b1, 32'hFFFF_FFFF};
        dir_rows[2]  = '{32'hDEAD_BEEF, 32'hFFFF_FFFF, 63'h0, 1'b1, 32'hDEAD_BEEF};
        // A zero leading CRC stays zero under any shift, so the trailing CRC comes through.
        dir_rows[3]  = '{32'h0000_0000, 32'hFFFF_FFFF, 63'h1, 1'b1, 32'hFFFF_FFFF};
        dir_rows[4]  = '{32'h0000_0000, 32'hA5A5_A5A5, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 32'hA5A5_A5A5};
        dir_rows[5]  = '{32'h0000_0000, 32'h0000_0000, 63'h4000_0000_0000_0000, 1'b1, 32'h0};
        dir_rows[6]  = '{32'hFFFF_FFFF, 32'h0000_0000, 63'h1, 1'b0, 32'h0};
        dir_rows[7]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0, 32'h0};
        dir_rows[8]  = '{32'h0000_0001, 32'h0000_0000, 63'h1, 1'b0, 32'h0};
        dir_rows[9]  = '{32'h8000_0000, 32'h0000_0000, 63'h4000_0000_0000_0000, 1'b0, 32'h0};
        dir_rows[10] = '{32'hFFFF_FFFF, 32'h5A5A_5A5A, 63'h4000_0000_0000_0000, 1'b0, 32'h0};
        dir_rows[11] = '{32'h1234_5678, 32'h9ABC_DEF0, 63'h2, 1'b0, 32'h0};
        dir_rows[12] = '{32'h1357_9BDF, 32'h2468_ACE0, 63'hFF, 1'b0, 32'h0};
        dir_rows[13] = '{32'hCAFE_F00D, 32'h0BAD_C0DE, 63'h100, 1'b0, 32'h0};
        dir_rows[14] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 63'h5555_5555_5555_5555, 1'b0, 32'h0};
        dir_rows[15] = '{32'h5555_5555, 32'hAAAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 32'h0};

        build_shift_ops();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct = 68;
                end
                1: begin
                    send_idle_pct = 68;
                    recv_idle_pct = 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0) begin
                for (int r = 0; r < NUM_ROWS; r++) begin
                    send_beat(dir_rows[r].first_crc, dir_rows[r].second_crc,
                              dir_rows[r].second_len, dir_rows[r].known, dir_rows[r].joined_crc);
                end
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_beat(rand_crc(), rand_crc(), rand_length(), 1'b0, '0);
            end
            // Hold the input off until the block has handed back everything in flight.
            i_s_axis_tvalid <= 1'b0;
            wait_all_results();
        end

        while (joined_crc_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
